FILE: sv/tsg_pkg.sv
// Shared types, constants and the sine table function of the turtle segment generator.
// Used by every module of the block; depends on nothing.

package tsg_pkg;

    localparam int STACK_DEPTH_DEFAULT = 1024;
    localparam int SINE_DEPTH_DEFAULT  = 1024;

    localparam int POS_W      = 24;
    localparam int ANGLE_W    = 16;
    localparam int LEN_W      = 16;
    localparam int TRIG_W     = 16;
    localparam int MAG_W      = 15;
    localparam int SYM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ENTRY_W    = ANGLE_W + 2 * POS_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd4;

    localparam logic [ANGLE_W-1:0] START_HEADING_RESET = 16'd16384;
    localparam logic [LEN_W-1:0]   STEP_LENGTH_RESET   = 16'd256;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_F     = 8'h46;
    localparam logic [SYM_W-1:0] SYM_X     = 8'h58;
    localparam logic [SYM_W-1:0] SYM_Y     = 8'h59;
    localparam logic [SYM_W-1:0] SYM_S     = 8'h53;
    localparam logic [SYM_W-1:0] SYM_G     = 8'h47;
    localparam logic [SYM_W-1:0] SYM_K     = 8'h4B;
    localparam logic [SYM_W-1:0] SYM_L     = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_H     = 8'h48;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;
    localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_FULL  = 2'd1,
        FAULT_EMPTY = 2'd2
    } tsg_fault_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_DRAW = 2'd1,
        OP_POP  = 2'd2
    } tsg_op_t;

    typedef struct packed {
        tsg_fault_t             fault;
        logic [POS_W-1:0]       to_y;
        logic [POS_W-1:0]       to_x;
        logic [POS_W-1:0]       from_y;
        logic [POS_W-1:0]       from_x;
        logic                   segment_valid;
    } tsg_result_t;

    // Q0.15 sine magnitude of a phase idx << shift in Q30 of a quarter turn,
    // odd Taylor series up to the eleventh power; evaluated at elaboration only
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned idx,
                                                  input int unsigned shift);
        longint unsigned r;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned mag;
        longint          s;
        r  = 64'(idx) << shift;
        u  = (r * HALF_PI_Q30) >> 30;
        u2 = (u * u) >> 30;
        s  = $signed(u);
        t  = ((u * u2) >> 30) / 6;
        s  = s - $signed(t);
        t  = ((t * u2) >> 30) / 20;
        s  = s + $signed(t);
        t  = ((t * u2) >> 30) / 42;
        s  = s - $signed(t);
        t  = ((t * u2) >> 30) / 72;
        s  = s + $signed(t);
        t  = ((t * u2) >> 30) / 110;
        s  = s - $signed(t);
        if (s < 0) begin
            s = 0;
        end
        mag = ($unsigned(s) + 64'h4000) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return mag[MAG_W-1:0];
    endfunction

endpackage

FILE: sv/tsg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Defaults from tsg_pkg.

module tsg_ram
    import tsg_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = STACK_DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

FILE: sv/tsg_sine.sv
// Sine and cosine lookup of a binary-angle heading from a quarter-wave table.
// Table built from tsg_pkg::sine_mag; results registered.

module tsg_sine
    import tsg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ANGLE_W-1:0]       heading,
    output logic signed [TRIG_W-1:0] sin_reg,
    output logic signed [TRIG_W-1:0] cos_reg
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int MIR_W   = IDX_W - 1;
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int QD      = QUARTER + 1;
    localparam int SHIFT   = 32 - IDX_W;

    logic [MAG_W-1:0] mag_tab [QD];

    for (genvar j = 0; j < QD; j++) begin : g_tab
        assign mag_tab[j] = sine_mag(j, SHIFT);
    end

    logic [IDX_W-1:0]         k_sin;
    logic [IDX_W-1:0]         k_cos;
    logic [MIR_W-1:0]         idx_sin;
    logic [MIR_W-1:0]         idx_cos;
    logic [MAG_W-1:0]         mag_sin;
    logic [MAG_W-1:0]         mag_cos;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;

    assign k_sin = heading[ANGLE_W-1 -: IDX_W];
    assign k_cos = k_sin + IDX_W'(QUARTER);

    // mirror the phase in odd quadrants, negate in the lower half turn
    always_comb begin
        idx_sin = k_sin[IDX_W-2] ? MIR_W'(QUARTER) - {1'b0, k_sin[IDX_W-3:0]}
                                 : {1'b0, k_sin[IDX_W-3:0]};
        idx_cos = k_cos[IDX_W-2] ? MIR_W'(QUARTER) - {1'b0, k_cos[IDX_W-3:0]}
                                 : {1'b0, k_cos[IDX_W-3:0]};
        mag_sin = mag_tab[idx_sin];
        mag_cos = mag_tab[idx_cos];
        sin_next = k_sin[IDX_W-1] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
        cos_next = k_cos[IDX_W-1] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

endmodule

FILE: sv/tsg_result_fifo.sv
// Two-entry result queue between the pose datapath and the master stream port.
// Uses tsg_result_t from tsg_pkg.

module tsg_result_fifo
    import tsg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  tsg_result_t in_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_ready,
    output tsg_result_t out_data
);

    tsg_result_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_next;
    logic [1:0]  count_next;
    logic        take;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);
    assign take      = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ in_valid;
        rd_ptr_next = rd_ptr_reg ^ take;
        count_next  = count_reg + 2'(in_valid) - 2'(take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> count_reg != 2'd2)
        else $error("result written into a full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

FILE: sv/turtle_segment_generator.sv
// Turtle segment generator: interprets each requested L-system symbol and emits segments.
// Depends on tsg_pkg, tsg_ram, tsg_sine and tsg_result_fifo.
//
// Channels: configuration writes on cfg_* (index 0 start_x, 1 start_y, 2 start_heading,
// 3 turn_step, 4 step_length; other indexes are dropped), written only while idle; the
// user must keep to this, the block does not enforce it. Symbols arrive on s_axis_*,
// one result per symbol leaves on m_axis_*. Each accepted symbol occupies the pose
// datapath in its accept cycle, when the heading drives the sine table and a pop reads
// the pose stack RAM, and then while busy_reg is set, when the scaled step is added to
// the position or the popped pose is loaded. While busy_reg is set s_axis_tready is low,
// so no symbol is taken until the last one has left the datapath; the loop runs from
// the sine table through the multiply-add into the position registers, and the stack
// RAM read is registered. The result is written into the result buffer while busy_reg
// is set and is offered on m_axis from there.
// Results queue in a two-entry buffer; while it is full s_axis_tready is held low, so a
// stalled receiver never loses or repeats a result.
// Reset loads the configuration defaults, clears the pose to zero and empties the stack;
// the stack RAM itself is not cleared, since only entries written by a push are read.

module turtle_segment_generator
    import tsg_pkg::*;
#(
    parameter int STACK_DEPTH      = STACK_DEPTH_DEFAULT,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] symbol
    input  logic [0:0]            s_axis_tuser,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [95:0]           m_axis_tdata,   // [23:0] from_x, [47:24] from_y,
                                                  // [71:48] to_x, [95:72] to_y
    output logic [2:0]            m_axis_tuser    // [0] segment_valid, [2:1] fault
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // configuration
    logic [POS_W-1:0]   start_x_reg;
    logic [POS_W-1:0]   start_y_reg;
    logic [ANGLE_W-1:0] start_heading_reg;
    logic [ANGLE_W-1:0] turn_step_reg;
    logic [LEN_W-1:0]   step_length_reg;

    // pose and control
    logic [POS_W-1:0]   pos_x_reg,   pos_x_next;
    logic [POS_W-1:0]   pos_y_reg,   pos_y_next;
    logic [ANGLE_W-1:0] heading_reg, heading_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               busy_reg,    busy_next;
    tsg_op_t            op_reg,      op_next;
    tsg_fault_t         fault_reg,   fault_next;

    logic               accept;
    logic               restart;
    logic [SYM_W-1:0]   symbol;
    logic [POS_W-1:0]   x_eff;
    logic [POS_W-1:0]   y_eff;
    logic [ANGLE_W-1:0] heading_eff;
    logic [CNT_W-1:0]   count_eff;
    logic [CNT_W-1:0]   count_dec;

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               trig_en;

    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [LEN_W:0]    step_s;
    logic signed [32:0]       prod_x;
    logic signed [32:0]       prod_y;
    logic signed [32:0]       sum_x;
    logic signed [32:0]       sum_y;
    logic [POS_W-1:0]         to_x;
    logic [POS_W-1:0]         to_y;

    tsg_result_t result;
    tsg_result_t out_item;
    logic        fifo_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= START_HEADING_RESET;
            turn_step_reg     <= '0;
            step_length_reg   <= STEP_LENGTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_X:       start_x_reg       <= cfg_data;
                REG_START_Y:       start_y_reg       <= cfg_data;
                REG_START_HEADING: start_heading_reg <= cfg_data[ANGLE_W-1:0];
                REG_TURN_STEP:     turn_step_reg     <= cfg_data[ANGLE_W-1:0];
                REG_STEP_LENGTH:   step_length_reg   <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !busy_reg && !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tuser[0];
    assign symbol        = s_axis_tdata;

    // restart reloads the pose and empties the stack before the symbol acts
    assign x_eff       = restart ? start_x_reg       : pos_x_reg;
    assign y_eff       = restart ? start_y_reg       : pos_y_reg;
    assign heading_eff = restart ? start_heading_reg : heading_reg;
    assign count_eff   = restart ? '0                : count_reg;
    assign count_dec   = count_eff - 1'b1;
    assign ram_wdata   = {heading_eff, y_eff, x_eff};

    // while busy_reg is set for a draw: scale the step and advance, rounding to nearest
    assign step_s = $signed({1'b0, step_length_reg});
    assign prod_x = step_s * cos_val;
    assign prod_y = step_s * sin_val;
    assign sum_x  = prod_x + 33'sd16384;
    assign sum_y  = prod_y + 33'sd16384;
    assign to_x   = pos_x_reg + {{(POS_W - 18){sum_x[32]}}, sum_x[32:15]};
    assign to_y   = pos_y_reg + {{(POS_W - 18){sum_y[32]}}, sum_y[32:15]};

    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        count_next   = count_reg;
        busy_next    = 1'b0;
        op_next      = OP_NONE;
        fault_next   = FAULT_NONE;
        ram_we       = 1'b0;
        trig_en      = 1'b0;
        if (busy_reg) begin
            unique case (op_reg)
                OP_DRAW: begin
                    pos_x_next = to_x;
                    pos_y_next = to_y;
                end
                OP_POP: begin
                    pos_x_next   = ram_rdata[POS_W-1:0];
                    pos_y_next   = ram_rdata[2*POS_W-1:POS_W];
                    heading_next = ram_rdata[ENTRY_W-1:2*POS_W];
                end
                default: ;
            endcase
        end else if (accept) begin
            busy_next    = 1'b1;
            pos_x_next   = x_eff;
            pos_y_next   = y_eff;
            heading_next = heading_eff;
            count_next   = count_eff;
            unique case (symbol) inside
                SYM_F, SYM_X, SYM_Y, SYM_S, SYM_G, SYM_K, SYM_L, SYM_H: begin
                    op_next = OP_DRAW;
                    trig_en = 1'b1;
                end
                SYM_PLUS:  heading_next = heading_eff + turn_step_reg;
                SYM_MINUS: heading_next = heading_eff - turn_step_reg;
                SYM_PUSH: begin
                    if (count_eff == CNT_W'(STACK_DEPTH)) begin
                        fault_next = FAULT_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_eff + 1'b1;
                    end
                end
                SYM_POP: begin
                    if (count_eff == '0) begin
                        fault_next = FAULT_EMPTY;
                    end else begin
                        op_next    = OP_POP;
                        count_next = count_dec;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            op_reg      <= OP_NONE;
            fault_reg   <= FAULT_NONE;
        end else begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            op_reg      <= op_next;
            fault_reg   <= fault_next;
        end
    end

    tsg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk      (aclk),
        .we        (ram_we),
        .waddr     (count_eff[AW-1:0]),
        .wdata     (ram_wdata),
        .raddr     (count_dec[AW-1:0]),
        .rdata_reg (ram_rdata)
    );

    tsg_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk    (aclk),
        .en      (trig_en),
        .heading (heading_eff),
        .sin_reg (sin_val),
        .cos_reg (cos_val)
    );

    always_comb begin
        result.segment_valid = (op_reg == OP_DRAW);
        result.from_x        = (op_reg == OP_DRAW) ? pos_x_reg : '0;
        result.from_y        = (op_reg == OP_DRAW) ? pos_y_reg : '0;
        result.to_x          = (op_reg == OP_DRAW) ? to_x      : '0;
        result.to_y          = (op_reg == OP_DRAW) ? to_y      : '0;
        result.fault         = fault_reg;
    end

    tsg_result_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (busy_reg),
        .in_data   (result),
        .full      (fifo_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item)
    );

    assign m_axis_tdata = {out_item.to_y, out_item.to_x, out_item.from_y, out_item.from_x};
    assign m_axis_tuser = {out_item.fault, out_item.segment_valid};

    a_two_cycle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |=> !busy_reg)
        else $error("pose datapath busy for more than one extra cycle");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg)
        else $error("accepted symbol did not enter the datapath");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond stack depth");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && symbol == SYM_POP && !restart && count_reg != '0
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not lower the stack count");

endmodule

FILE: tb/turtle_segment_checker.sv
// Result checker for the turtle segment generator: tracks configuration writes and symbol
// requests, predicts each result from its own pose and stack model and compares the outputs.
// Depends on tsg_pkg for widths, symbol codes, register indexes and the result type.
`timescale 1ns / 100ps

module turtle_segment_checker
    import tsg_pkg::*;
#(
    parameter int STACK_DEPTH      = STACK_DEPTH_DEFAULT,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] symbol
    input  logic [0:0]            s_axis_tuser,   // [0] restart
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [95:0]           m_axis_tdata,   // [23:0] from_x, [47:24] from_y,
                                                  // [71:48] to_x, [95:72] to_y
    input  logic [2:0]            m_axis_tuser,   // [0] segment_valid, [2:1] fault
    output int                    mismatches,
    output int                    results_seen,
    output int                    results_owed
);

    localparam int REPORT_LIMIT = 64;

    // configuration copy
    logic [POS_W-1:0]   start_x;
    logic [POS_W-1:0]   start_y;
    logic [ANGLE_W-1:0] start_heading;
    logic [ANGLE_W-1:0] turn_step;
    logic [LEN_W-1:0]   step_len;

    // turtle pose and saved poses
    logic [POS_W-1:0]   pose_x;
    logic [POS_W-1:0]   pose_y;
    logic [ANGLE_W-1:0] pose_heading;
    logic [ENTRY_W-1:0] saved_poses [STACK_DEPTH];
    int                 saved_count;

    tsg_result_t        pending_results [$];
    int                 mismatch_total;
    int                 result_total;

    // Q1.15 sine of a Q32 phase: fold into the first quadrant, then odd Taylor terms
    function automatic int table_sine(input logic [31:0] phase);
        logic [1:0]      quadrant;
        longint unsigned rem;
        longint unsigned rad;
        longint unsigned rad2;
        longint unsigned term;
        longint          series;
        longint          mag;
        quadrant = phase[31:30];
        rem = 64'(phase[29:0]);
        if (quadrant[0]) begin
            rem = (64'd1 << 30) - rem;
        end
        rad    = (rem * HALF_PI_Q30) >> 30;
        rad2   = (rad * rad) >> 30;
        series = longint'(rad);
        term   = rad;
        for (int i = 0; i < 5; i++) begin
            term = ((term * rad2) >> 30) / ((2 * i + 2) * (2 * i + 3));
            if (i % 2 == 0) begin
                series = series - longint'(term);
            end else begin
                series = series + longint'(term);
            end
        end
        if (series < 0) begin
            series = 0;
        end
        mag = (series + 16384) >> 15;
        if (mag > 32767) begin
            mag = 32767;
        end
        return quadrant[1] ? -int'(mag) : int'(mag);
    endfunction

    // step length times a trig value, rounded and floored back to Q15.8
    function automatic logic [POS_W-1:0] scaled_step(input int trig);
        longint prod;
        prod = longint'(step_len) * trig + 16384;
        return POS_W'(prod >>> 15);
    endfunction

    function automatic tsg_result_t interpret_symbol(input logic [SYM_W-1:0] sym,
                                                     input logic restart);
        tsg_result_t     res;
        longint unsigned slot;
        longint unsigned phase;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        res = '0;
        if (restart) begin
            pose_x       = start_x;
            pose_y       = start_y;
            pose_heading = start_heading;
            saved_count  = 0;
        end
        case (sym)
            SYM_F, SYM_X, SYM_Y, SYM_S, SYM_G, SYM_K, SYM_L, SYM_H: begin
                slot  = (64'(pose_heading) * SINE_TABLE_DEPTH) >> ANGLE_W;
                phase = (slot << 32) / SINE_TABLE_DEPTH;
                dx = scaled_step(table_sine(32'(phase) + 32'h4000_0000));
                dy = scaled_step(table_sine(32'(phase)));
                res.segment_valid = 1'b1;
                res.from_x = pose_x;
                res.from_y = pose_y;
                pose_x = pose_x + dx;
                pose_y = pose_y + dy;
                res.to_x = pose_x;
                res.to_y = pose_y;
            end
            SYM_PLUS: begin
                pose_heading = pose_heading + turn_step;
            end
            SYM_MINUS: begin
                pose_heading = pose_heading - turn_step;
            end
            SYM_PUSH: begin
                if (saved_count >= STACK_DEPTH) begin
                    res.fault = FAULT_FULL;
                end else begin
                    saved_poses[saved_count] = {pose_heading, pose_y, pose_x};
                    saved_count++;
                end
            end
            SYM_POP: begin
                if (saved_count == 0) begin
                    res.fault = FAULT_EMPTY;
                end else begin
                    saved_count--;
                    {pose_heading, pose_y, pose_x} = saved_poses[saved_count];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string label, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got) begin
            if (mismatch_total < REPORT_LIMIT) begin
                $display("%0t: result %0d %s expected %h, got %h",
                         $time, result_total, label, want, got);
            end
            mismatch_total++;
        end
    endtask

    task automatic compare_result(input tsg_result_t want, input tsg_result_t got);
        check_field("segment_valid", POS_W'(want.segment_valid), POS_W'(got.segment_valid));
        check_field("from_x", want.from_x, got.from_x);
        check_field("from_y", want.from_y, got.from_y);
        check_field("to_x", want.to_x, got.to_x);
        check_field("to_y", want.to_y, got.to_y);
        check_field("fault", POS_W'(want.fault), POS_W'(got.fault));
    endtask

    always @(posedge aclk) begin : watch
        tsg_result_t got;
        if (!aresetn) begin
            start_x        = '0;
            start_y        = '0;
            start_heading  = START_HEADING_RESET;
            turn_step      = '0;
            step_len       = STEP_LENGTH_RESET;
            pose_x         = '0;
            pose_y         = '0;
            pose_heading   = '0;
            saved_count    = 0;
            mismatch_total = 0;
            result_total   = 0;
            pending_results.delete();
        end else begin
            // compare before predicting: a result never belongs to a same-edge request
            if (m_axis_tvalid && m_axis_tready) begin
                got.from_x        = m_axis_tdata[23:0];
                got.from_y        = m_axis_tdata[47:24];
                got.to_x          = m_axis_tdata[71:48];
                got.to_y          = m_axis_tdata[95:72];
                got.segment_valid = m_axis_tuser[0];
                got.fault         = tsg_fault_t'(m_axis_tuser[2:1]);
                if (pending_results.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected, expected none, got %h %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                    end
                    mismatch_total++;
                end else begin
                    compare_result(pending_results.pop_front(), got);
                end
                result_total++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_X:       start_x       = cfg_data[POS_W-1:0];
                    REG_START_Y:       start_y       = cfg_data[POS_W-1:0];
                    REG_START_HEADING: start_heading = cfg_data[ANGLE_W-1:0];
                    REG_TURN_STEP:     turn_step     = cfg_data[ANGLE_W-1:0];
                    REG_STEP_LENGTH:   step_len      = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(interpret_symbol(s_axis_tdata[SYM_W-1:0],
                                                           s_axis_tuser[0]));
            end
        end
        mismatches   <= mismatch_total;
        results_seen <= result_total;
        results_owed <= pending_results.size();
    end

endmodule

FILE: tb/turtle_segment_generator_test.sv
// Top of the turtle segment generator testbench: clock, reset, symbol and configuration
// stimulus, a stalling result sink and the verdict. Depends on tsg_pkg, the block and
// turtle_segment_checker.
`timescale 1ns / 100ps

module turtle_segment_generator_test;
    import tsg_pkg::*;

    localparam int STACK_DEPTH    = STACK_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 64;
    localparam int FILL_DEPTH     = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // symbols the block ignores
    localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hFF;
    localparam logic [SYM_W-1:0] SYM_LETTER_A = 8'h41;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_START_X;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] symbol
    logic [0:0]            s_axis_tuser  = '0;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [95:0]           m_axis_tdata;   // [23:0] from_x, [47:24] from_y,
                                           // [71:48] to_x, [95:72] to_y
    logic [2:0]            m_axis_tuser;   // [0] segment_valid, [2:1] fault

    int mismatches;
    int results_seen;
    int results_owed;
    int items_sent     = 0;
    int settings_used  = 0;
    int open_brackets  = 0;
    int idle_cycles    = 0;
    bit send_calm      = 1'b0;
    bit sink_calm      = 1'b0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    turtle_segment_generator #(
        .STACK_DEPTH      (STACK_DEPTH),
        .SINE_TABLE_DEPTH (SINE_DEPTH_DEFAULT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    turtle_segment_checker #(
        .STACK_DEPTH      (STACK_DEPTH),
        .SINE_TABLE_DEPTH (SINE_DEPTH_DEFAULT)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .results_seen  (results_seen),
        .results_owed  (results_owed)
    );

    function automatic logic [SYM_W-1:0] draw_letter(input int n);
        case (n % 8)
            0:       return SYM_F;
            1:       return SYM_X;
            2:       return SYM_Y;
            3:       return SYM_S;
            4:       return SYM_G;
            5:       return SYM_K;
            6:       return SYM_L;
            default: return SYM_H;
        endcase
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic restart);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= restart;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold valid between writes; program_pose drops it after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_pose(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic [ANGLE_W-1:0] hdg,
                                input logic [ANGLE_W-1:0] turn,
                                input logic [LEN_W-1:0] len);
        // an unused index first: the block must drop it
        write_reg(CFG_IDX_W'($urandom_range(REG_STEP_LENGTH + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_START_X, x);
        write_reg(REG_START_Y, y);
        // upper bits of the narrow registers carry noise that must be masked
        write_reg(REG_START_HEADING, {8'($urandom), hdg});
        write_reg(REG_TURN_STEP, {8'($urandom), turn});
        write_reg(REG_STEP_LENGTH, {8'($urandom), len});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge aclk);
    endtask

    // mostly well-formed strings: draws, turns and balanced brackets, some noise
    task automatic random_symbols(input int count);
        logic [SYM_W-1:0] sym;
        logic             restart;
        int               roll;
        for (int i = 0; i < count; i++) begin
            restart = (i == 0) || ($urandom_range(0, 39) == 0);
            if (restart) begin
                open_brackets = 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                sym = draw_letter($urandom_range(0, 7));
            end else if (roll < 55) begin
                sym = SYM_PLUS;
            end else if (roll < 70) begin
                sym = SYM_MINUS;
            end else if (roll < 80 ||
                         (roll < 90 && open_brackets == 0 && $urandom_range(0, 3) != 0)) begin
                sym = SYM_PUSH;
            end else if (roll < 90) begin
                sym = SYM_POP;
            end else begin
                sym = SYM_W'($urandom);
            end
            case (sym)
                SYM_PUSH: if (open_brackets < STACK_DEPTH) open_brackets++;
                SYM_POP:  if (open_brackets > 0) open_brackets--;
                default: ;
            endcase
            send_symbol(sym, restart);
        end
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge aclk);
        forever begin
            if (taken % 40 == 0) begin
                sink_calm = ($urandom_range(0, 2) == 0);
            end
            stall = sink_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("turtle_segment_generator test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset pose, heading zero, before any restart
        send_symbol(SYM_F, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_NUL, 1'b0);
        send_symbol(SYM_ALL_ONES, 1'b0);
        // restart with an ignored symbol loads the default start pose
        send_symbol(SYM_LETTER_A, 1'b1);
        send_symbol(SYM_PLUS, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        for (int n = 0; n < 8; n++) begin
            send_symbol(draw_letter(n), 1'b0);
        end
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_X, 1'b1);
        send_symbol(SYM_PUSH, 1'b0);
        // restart empties the stack before the pop acts
        send_symbol(SYM_POP, 1'b1);
        wait_idle();

        // upper extremes: positions wrap on the first steps
        program_pose(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_symbols(RANDOM_ITEMS);
        wait_idle();

        // lower extremes and a half turn, zero step length
        program_pose(24'h800000, 24'h800000, 16'h0000, 16'h8000, 16'h0000);
        random_symbols(RANDOM_ITEMS / 2);
        wait_idle();

        // build a deep stack of distinct poses, drain it and pop once more
        program_pose(POS_W'($urandom), POS_W'($urandom), ANGLE_W'($urandom),
                     ANGLE_W'($urandom_range(64, 65535) | 1), LEN_W'($urandom));
        send_symbol(SYM_PLUS, 1'b1);
        for (int i = 0; i < FILL_DEPTH; i++) begin
            if (i % 8 == 0) begin
                send_symbol(draw_letter($urandom_range(0, 7)), 1'b0);
            end
            send_symbol(SYM_PUSH, 1'b0);
            send_symbol(SYM_PLUS, 1'b0);
        end
        for (int i = 0; i < FILL_DEPTH; i++) begin
            send_symbol(SYM_POP, 1'b0);
            if (i % 4 == 3) begin
                send_symbol(draw_letter($urandom_range(0, 7)), 1'b0);
            end
        end
        send_symbol(SYM_POP, 1'b0);
        open_brackets = 0;
        wait_idle();

        repeat (4) begin
            program_pose(POS_W'($urandom), POS_W'($urandom), ANGLE_W'($urandom),
                         ANGLE_W'($urandom_range(0, 1) ? ($urandom_range(1, 63) << 10)
                                                       : $urandom),
                         LEN_W'($urandom));
            random_symbols(RANDOM_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d symbols under %0d pose settings, including a deep stack fill",
                 items_sent, settings_used);
        $display("Compared %0d results, %0d field mismatches", results_seen, mismatches);
        if (results_owed != 0) begin
            $display("%0t: %0d expected results never arrived", $time, results_owed);
        end
        if (mismatches == 0 && results_owed == 0) begin
            $display("turtle_segment_generator test passed");
        end else begin
            $display("turtle_segment_generator test failed");
        end
        $finish;
    end

endmodule

FILE: turtle_segment_generator.f
sv/tsg_pkg.sv
sv/tsg_ram.sv
sv/tsg_sine.sv
sv/tsg_result_fifo.sv
sv/turtle_segment_generator.sv
tb/turtle_segment_checker.sv
tb/turtle_segment_generator_test.sv
